// ===== design/pba_pkg.sv =====
// Shared types, sizes and status codes of the page bitmap allocator.
// The bitmap is kept as words of WORD_W bits, one summary flag per word.
// No dependencies.
package pba_pkg;

  localparam int NUM_PAGES  = 4096;
  localparam int PAGE_SHIFT = 12;

  localparam int WORD_W    = 64;
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int NUM_WORDS = (NUM_PAGES + WORD_W - 1) / WORD_W;
  localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int LAST_BITS = NUM_PAGES - (NUM_WORDS - 1) * WORD_W;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [WIDX_W-1:0] widx_t;
  typedef logic [BIT_W-1:0]  bidx_t;

  localparam widx_t LAST_WORD = WIDX_W'(NUM_WORDS - 1);
  localparam word_t PAD_MASK  = ~((word_t'(1) << LAST_BITS) - word_t'(1));
  localparam logic [31:0] LOW_MASK = (32'd1 << PAGE_SHIFT) - 32'd1;

  localparam logic [2:0] STATUS_ALLOCATED  = 3'd0;
  localparam logic [2:0] STATUS_NONE_FREE  = 3'd1;
  localparam logic [2:0] STATUS_FREED      = 3'd2;
  localparam logic [2:0] STATUS_MISALIGNED = 3'd3;
  localparam logic [2:0] STATUS_OUT_RANGE  = 3'd4;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef struct packed {
    logic  en;
    widx_t addr;
  } map_rd_t;

  typedef struct packed {
    logic  en;
    widx_t addr;
    word_t data;
  } map_wr_t;

  function automatic bidx_t lowest_zero(word_t w);
    bidx_t r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!w[i]) begin
        r = BIT_W'(i);
      end
    end
    return r;
  endfunction

endpackage

// ===== design/pba_map_mem.sv =====
// Bitmap word memory with a registered read port and one write port.
// Rows carry valid flags cleared at reset; an unwritten row reads as zero.
// Depends on pba_pkg.
module pba_map_mem
  import pba_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  map_rd_t rd_i,
  output word_t   rd_data_o,
  input  map_wr_t wr_i
);

  word_t                 mem [NUM_WORDS];
  logic [NUM_WORDS-1:0]  row_valid_q;
  word_t                 rd_word_q;
  logic                  rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      rd_word_q <= mem[rd_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      if (wr_i.en) begin
        row_valid_q[wr_i.addr] <= 1'b1;
      end
      if (rd_i.en) begin
        rd_valid_q <= row_valid_q[rd_i.addr];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_word_q : '0;

endmodule

// ===== design/page_bitmap_allocator_unit.sv =====
// Top level of the first-fit page frame allocator.
// Depends on pba_pkg and pba_map_mem.
//
// Requests enter on the s_axis channel: tuser holds the kind (allocate or
// free) and tdata the byte address to free. Each request gives exactly one
// result on the m_axis channel: tuser holds the status code and tdata the
// allocated page address, zero for any other status.
// The result passes through states ST_RD and ST_WR: ST_RD picks the bitmap
// word and reads it; ST_WR updates the word and loads the result, waiting
// while the output register holds an untaken result. The next request is
// accepted only after that load, so no new request is taken before the last
// one is through, bounded by the read and write-back of the bitmap memory.
// A summary flag per word marks full words, so the free word is found
// without scanning the memory.
// Reset empties the map at once via per-row valid flags; no clearing pass.
// The user must write the region base through cfg_we_i only while idle;
// the block does not enforce this. If the receiver stalls, the result holds
// in the output register, one more request may be accepted and read, and it
// then waits before its write-back until the output register is free.
module page_bitmap_allocator_unit
  import pba_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [31:0] free_address
  input  logic [0:0]  s_axis_tuser,  // [0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [31:0] page_address
  output logic [2:0]  m_axis_tuser   // [2:0] status
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_WR   = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [31:0]          base_q;
  logic [NUM_WORDS-1:0] full_q;
  logic                 cmd_q;
  logic [31:0]          addr_q;
  widx_t                widx_q, widx_d;
  bidx_t                bit_q, bit_d;
  logic [2:0]           status_q, status_d;
  logic                 out_valid_q;
  logic [31:0]          out_addr_q;
  logic [2:0]           out_status_q;

  map_rd_t     map_rd;
  map_wr_t     map_wr;
  word_t       rd_data;
  word_t       word_eff;
  word_t       word_new;
  bidx_t       alloc_bit;
  logic [31:0] offset;
  logic [31:0] page_addr;
  logic        found;
  widx_t       found_idx;
  logic        load_out;
  logic        do_write;

  pba_map_mem u_map_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_i      (map_rd),
    .rd_data_o (rd_data),
    .wr_i      (map_wr)
  );

  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = NUM_WORDS - 1; i >= 0; i--) begin
      if (!full_q[i]) begin
        found     = 1'b1;
        found_idx = WIDX_W'(i);
      end
    end
  end

  assign offset = addr_q - base_q;

  always_comb begin
    widx_d   = found_idx;
    bit_d    = '0;
    status_d = found ? STATUS_ALLOCATED : STATUS_NONE_FREE;
    if (cmd_q == CMD_FREE) begin
      widx_d = WIDX_W'(offset >> (PAGE_SHIFT + BIT_W));
      bit_d  = offset[PAGE_SHIFT +: BIT_W];
      if ((offset & LOW_MASK) != 32'd0) begin
        status_d = STATUS_MISALIGNED;
      end else if ((offset >> PAGE_SHIFT) >= 32'(NUM_PAGES)) begin
        status_d = STATUS_OUT_RANGE;
      end else begin
        status_d = STATUS_FREED;
      end
    end
  end

  assign word_eff  = rd_data | ((widx_q == LAST_WORD) ? PAD_MASK : '0);
  assign alloc_bit = lowest_zero(word_eff);
  assign page_addr = base_q + (32'({widx_q, alloc_bit}) << PAGE_SHIFT);

  always_comb begin
    if (cmd_q == CMD_ALLOC) begin
      word_new = rd_data | (word_t'(1) << alloc_bit);
    end else begin
      word_new = rd_data & ~(word_t'(1) << bit_q);
    end
  end

  assign load_out = (state_q == ST_WR) && (!out_valid_q || m_axis_tready);
  assign do_write = load_out &&
                    (status_q == STATUS_ALLOCATED || status_q == STATUS_FREED);

  assign map_rd.en   = (state_q == ST_RD);
  assign map_rd.addr = widx_d;
  assign map_wr.en   = do_write;
  assign map_wr.addr = widx_q;
  assign map_wr.data = word_new;

  assign s_axis_tready = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        state_d = ST_WR;
      end
      ST_WR: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      base_q      <= '0;
      full_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
      if (do_write) begin
        full_q[widx_q] <= &(word_new | ((widx_q == LAST_WORD) ? PAD_MASK : '0));
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_q  <= s_axis_tuser[0];
      addr_q <= s_axis_tdata;
    end
    if (state_q == ST_RD) begin
      widx_q   <= widx_d;
      bit_q    <= bit_d;
      status_q <= status_d;
    end
    if (load_out) begin
      out_status_q <= status_q;
      out_addr_q   <= (status_q == STATUS_ALLOCATED) ? page_addr : 32'd0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_addr_q;
  assign m_axis_tuser  = out_status_q;

  a_alloc_word_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WR && cmd_q == CMD_ALLOC && status_q == STATUS_ALLOCATED)
      |-> !full_q[widx_q])
    else $error("allocation picked a word marked full");

  a_write_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    map_wr.en |=> (m_axis_tvalid &&
                   (m_axis_tuser == STATUS_ALLOCATED || m_axis_tuser == STATUS_FREED)))
    else $error("bitmap write without a matching result");

  a_alloc_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == STATUS_ALLOCATED)
      |-> (((m_axis_tdata ^ base_q) & LOW_MASK) == 32'd0))
    else $error("allocated address is not page aligned to the region");

  a_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != STATUS_ALLOCATED) |-> (m_axis_tdata == 32'd0))
    else $error("nonzero address with a non-allocate status");

endmodule
